[hw/rtl/mrv_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response validator package
// Shared sizes, register indexes, frame descriptor and back-end state type.
// ----------------------------------------------------------------------------
package mrv_pkg;

  // Word buffer sizing: one bank of MAX_WORDS words per frame, two banks.
  localparam int MAX_WORDS     = 32;
  localparam int WIDX_W        = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int NWORDS_W      = $clog2(MAX_WORDS + 1);
  localparam int MEM_AW        = WIDX_W + 1;
  localparam int MEM_DEPTH     = 2 ** MEM_AW;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

  // Frame layout and checks.
  localparam int POS_ADDR      = 0;
  localparam int POS_FUNC      = 1;
  localparam int POS_COUNT     = 2;
  localparam int POS_DATA      = 3;
  localparam int POS_FIRST_LOW = POS_DATA + 1;
  localparam int LAST_WORD_POS = 2 * MAX_WORDS + POS_DATA;
  localparam int LEN_OVERHEAD  = 5;
  localparam int MAX_FRAME_LEN = 2 * MAX_WORDS + LEN_OVERHEAD;
  localparam int MIN_LEN_FLOOR = 4;
  localparam logic [7:0]  POS_MAX   = 8'hFF;
  localparam logic [7:0]  ANY_ADDR  = 8'hFF;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_OWN_ADDR   = 2'd0,
    REG_READ_CODE  = 2'd1,
    REG_WRITE_CODE = 2'd2,
    REG_MIN_LEN    = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [7:0] own_address;
    logic [6:0] read_code;
    logic [6:0] write_code;
    logic [3:0] min_frame_len;
  } cfg_regs_t;

  // Verdict of one closed frame, passed from front to back.
  typedef struct packed {
    logic                ok;
    logic                exc;
    logic [7:0]          exc_code;
    logic [NWORDS_W-1:0] nwords;
    logic                bank;
  } frame_desc_t;

  // Word buffer write port.
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [15:0]       data;
  } mem_wr_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD,
    BK_STATUS
  } back_state_t;

endpackage

[hw/rtl/mrv_front.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response validator front end
// Takes frame bytes, runs the CRC, latches header bytes, writes register
// words into the current buffer bank and pushes a verdict at frame end.
// ----------------------------------------------------------------------------
module mrv_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,
  input  logic                   in_tlast,
  input  mrv_pkg::cfg_regs_t     cfg,
  input  logic                   frame_done,
  output mrv_pkg::mem_wr_t       mem_wr,
  output logic                   push,
  output mrv_pkg::frame_desc_t   push_desc
);

  // One CRC-16/MODBUS byte update, bit by bit.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'd0, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ mrv_pkg::CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  func_r, func_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  pending_r, pending_nxt;
  logic [15:0] tail_r, tail_nxt;
  logic        bank_r, bank_nxt;
  logic [1:0]  frames_r, frames_nxt;

  logic        accept;
  logic [15:0] crc_fed;
  logic [7:0]  len;
  logic [7:0]  minlen;
  logic [7:0]  word_off;
  logic [8:0]  count_plus;
  logic [8:0]  half_words;
  logic        ok, exc, normal;

  // Two frames may be outstanding, one per buffer bank.
  assign in_tready = (frames_r != 2'(mrv_pkg::QUEUE_DEPTH));
  assign accept    = in_tvalid & in_tready;

  // Per-byte datapath and frame verdict.
  always_comb begin
    crc_fed    = (pos_r >= 8'(mrv_pkg::POS_COUNT)) ? crc_feed(crc_r, tail_r[15:8]) : crc_r;
    len        = (pos_r == mrv_pkg::POS_MAX) ? pos_r : pos_r + 8'd1;
    minlen     = (cfg.min_frame_len < 4'(mrv_pkg::MIN_LEN_FLOOR)) ?
                 8'(mrv_pkg::MIN_LEN_FLOOR) : {4'd0, cfg.min_frame_len};
    word_off   = pos_r - 8'(mrv_pkg::POS_FIRST_LOW);
    count_plus = {1'b0, count_r} + 9'(mrv_pkg::LEN_OVERHEAD);
    half_words = ({1'b0, count_r} + 9'd1) >> 1;
    exc        = func_r[7];

    ok = (len >= minlen) && (len <= 8'(mrv_pkg::MAX_FRAME_LEN)) &&
         (crc_fed[7:0] == tail_r[7:0]) && (crc_fed[15:8] == in_tdata) &&
         ((func_r[6:0] == cfg.read_code) || (func_r[6:0] == cfg.write_code)) &&
         ((cfg.own_address == mrv_pkg::ANY_ADDR) || (cfg.own_address == addr_r));
    ok = ok && (exc || (count_plus == {1'b0, len}));
    normal = ok && !exc;

    push                = accept && in_tlast;
    push_desc.ok        = ok;
    push_desc.exc       = ok && exc;
    push_desc.exc_code  = (ok && exc) ? count_r : 8'd0;
    push_desc.nwords    = normal ? half_words[mrv_pkg::NWORDS_W-1:0] : '0;
    push_desc.bank      = bank_r;

    mem_wr.en   = accept && (pos_r >= 8'(mrv_pkg::POS_FIRST_LOW)) && !pos_r[0] &&
                  (pos_r <= 8'(mrv_pkg::LAST_WORD_POS));
    mem_wr.addr = {bank_r, word_off[mrv_pkg::WIDX_W:1]};
    mem_wr.data = {pending_r, in_tdata};
  end

  // Next frame state.
  always_comb begin
    crc_nxt     = crc_r;
    pos_nxt     = pos_r;
    addr_nxt    = addr_r;
    func_nxt    = func_r;
    count_nxt   = count_r;
    pending_nxt = pending_r;
    tail_nxt    = tail_r;
    bank_nxt    = bank_r;
    if (accept) begin
      if (in_tlast) begin
        crc_nxt     = mrv_pkg::CRC_INIT;
        pos_nxt     = 8'd0;
        addr_nxt    = 8'd0;
        func_nxt    = 8'd0;
        count_nxt   = 8'd0;
        pending_nxt = 8'd0;
        tail_nxt    = 16'd0;
        bank_nxt    = ~bank_r;
      end else begin
        crc_nxt  = crc_fed;
        pos_nxt  = len;
        tail_nxt = {tail_r[7:0], in_tdata};
        if (pos_r == 8'(mrv_pkg::POS_ADDR)) begin
          addr_nxt = in_tdata;
        end else if (pos_r == 8'(mrv_pkg::POS_FUNC)) begin
          func_nxt = in_tdata;
        end else if (pos_r == 8'(mrv_pkg::POS_COUNT)) begin
          count_nxt = in_tdata;
        end else if (pos_r[0]) begin
          pending_nxt = in_tdata;
        end
      end
    end
    frames_nxt = frames_r + {1'b0, push} - {1'b0, frame_done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r     <= mrv_pkg::CRC_INIT;
      pos_r     <= 8'd0;
      addr_r    <= 8'd0;
      func_r    <= 8'd0;
      count_r   <= 8'd0;
      pending_r <= 8'd0;
      tail_r    <= 16'd0;
      bank_r    <= 1'b0;
      frames_r  <= 2'd0;
    end else begin
      crc_r     <= crc_nxt;
      pos_r     <= pos_nxt;
      addr_r    <= addr_nxt;
      func_r    <= func_nxt;
      count_r   <= count_nxt;
      pending_r <= pending_nxt;
      tail_r    <= tail_nxt;
      bank_r    <= bank_nxt;
      frames_r  <= frames_nxt;
    end
  end

endmodule

[hw/rtl/mrv_queue.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response validator verdict queue
// Small FIFO of frame descriptors between the front and back ends.
// ----------------------------------------------------------------------------
module mrv_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  mrv_pkg::frame_desc_t   push_desc,
  input  logic                   pop,
  output mrv_pkg::frame_desc_t   head,
  output logic                   empty
);

  mrv_pkg::frame_desc_t          entry_r [mrv_pkg::QUEUE_DEPTH];
  logic [mrv_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [mrv_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [mrv_pkg::QCNT_W-1:0]    count_r, count_nxt;

  assign head  = entry_r[rd_ptr_r];
  assign empty = (count_r == '0);

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + mrv_pkg::QCNT_W'(push) - mrv_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Descriptor storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  // The front end must never push into a full queue.
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != mrv_pkg::QCNT_W'(mrv_pkg::QUEUE_DEPTH) || pop))
    else $error("verdict pushed into a full queue");

  // The back end must never pop an empty queue.
  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("verdict popped from an empty queue");

endmodule

[hw/rtl/mrv_back.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response validator back end
// Holds the two-bank word buffer and emits the words of each accepted
// frame, then a status beat for every frame, through an output register.
// ----------------------------------------------------------------------------
module mrv_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  mrv_pkg::mem_wr_t       mem_wr,
  input  logic                   q_empty,
  input  mrv_pkg::frame_desc_t   q_head,
  output logic                   q_pop,
  output logic                   frame_done,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [23:0]            out_tdata,
  output logic                   out_tlast,
  output logic [1:0]             out_tuser
);

  logic [15:0]                     mem_r [mrv_pkg::MEM_DEPTH];
  logic [15:0]                     rd_data_r;

  mrv_pkg::back_state_t            state_r, state_nxt;
  mrv_pkg::frame_desc_t            desc_r;
  logic [mrv_pkg::NWORDS_W-1:0]    word_idx_r, word_idx_nxt;

  logic        out_valid_r;
  logic [15:0] out_word_r;
  logic [7:0]  out_code_r;
  logic        out_last_r, out_ok_r, out_exc_r;

  logic        out_free, rd_en, load_word, load_status;
  logic [mrv_pkg::MEM_AW-1:0] rd_addr;

  assign out_free = !out_valid_r || out_tready;
  assign rd_addr  = {desc_r.bank, word_idx_r[mrv_pkg::WIDX_W-1:0]};
  assign word_idx_nxt = word_idx_r + 1'b1;

  // Word buffer: written by the front end, read one word at a time here.
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      mem_r[mem_wr.addr] <= mem_wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mrv_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_head.nwords != '0) ? mrv_pkg::BK_READ : mrv_pkg::BK_STATUS;
        end
      end
      mrv_pkg::BK_READ: begin
        state_nxt = mrv_pkg::BK_LOAD;
      end
      mrv_pkg::BK_LOAD: begin
        if (out_free) begin
          state_nxt = (word_idx_nxt == desc_r.nwords) ? mrv_pkg::BK_STATUS :
                                                         mrv_pkg::BK_READ;
        end
      end
      mrv_pkg::BK_STATUS: begin
        if (out_free) begin
          state_nxt = mrv_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = mrv_pkg::BK_IDLE;
      end
    endcase
  end

  // State outputs.
  always_comb begin
    q_pop       = 1'b0;
    rd_en       = 1'b0;
    load_word   = 1'b0;
    load_status = 1'b0;
    case (state_r)
      mrv_pkg::BK_IDLE:   q_pop       = !q_empty;
      mrv_pkg::BK_READ:   rd_en       = 1'b1;
      mrv_pkg::BK_LOAD:   load_word   = out_free;
      mrv_pkg::BK_STATUS: load_status = out_free;
      default: begin
        q_pop = 1'b0;
      end
    endcase
    frame_done = load_status;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrv_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      word_idx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (load_word || load_status) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (q_pop) begin
        word_idx_r <= '0;
      end else if (load_word) begin
        word_idx_r <= word_idx_nxt;
      end
    end
  end

  // Descriptor and output payload.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_head;
    end
    if (load_word) begin
      out_word_r <= rd_data_r;
      out_last_r <= 1'b0;
      out_ok_r   <= 1'b0;
      out_exc_r  <= 1'b0;
      out_code_r <= 8'd0;
    end else if (load_status) begin
      out_word_r <= 16'd0;
      out_last_r <= 1'b1;
      out_ok_r   <= desc_r.ok;
      out_exc_r  <= desc_r.exc;
      out_code_r <= desc_r.exc_code;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_code_r, out_word_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_exc_r, out_ok_r};

  // A word beat is only loaded for a word the frame actually carries.
  a_word_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    load_word |-> (word_idx_r < desc_r.nwords))
    else $error("word beat beyond the frame's word count");

  // The status beat follows exactly all of the frame's words.
  a_status_after_words: assert property (@(posedge clk) disable iff (!rst_n)
    load_status |-> (word_idx_r == desc_r.nwords))
    else $error("status beat sent before all words");

endmodule

[hw/rtl/modbus_rtu_response_validator.sv]
// ----------------------------------------------------------------------------
// Modbus RTU response validator
// Checks Modbus RTU response frames (CRC, address, function, length) and
// emits the register words of accepted frames followed by a status beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  in_*      slave      one frame byte per beat, tlast on the last byte
//  out_*     master     register word beats, then one status beat (tlast)
//  cfg_*     APB        own_address, read_code, write_code, min_frame_len
//
//  The front end takes one byte per cycle while in_tready is high and closes
//  a frame in the cycle of its last byte. A word beat is a buffer read, then
//  an output load in the back end; the status beat follows. in_tready drops
//  while two frames are waiting for or in emission, one per buffer bank.
//  Reset is synchronous; no clearing pass is needed after it.
// ----------------------------------------------------------------------------
module modbus_rtu_response_validator (
  input  logic        clk,
  input  logic        rst_n,
  // Input bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // frame_end
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] reg_word, [23:16] exception_code
  output logic        out_tlast,  // last
  output logic [1:0]  out_tuser,  // [0] frame_valid, [1] has_exception
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  mrv_pkg::cfg_regs_t    cfg_r;
  mrv_pkg::reg_idx_t     reg_idx;
  mrv_pkg::mem_wr_t      mem_wr;
  mrv_pkg::frame_desc_t  push_desc, q_head;
  logic                  cfg_wr, push, pop, q_empty, frame_done;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = mrv_pkg::reg_idx_t'(cfg_paddr[3:2]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.own_address   <= 8'd255;
      cfg_r.read_code     <= 7'd3;
      cfg_r.write_code    <= 7'd16;
      cfg_r.min_frame_len <= 4'd5;
    end else if (cfg_wr) begin
      case (reg_idx)
        mrv_pkg::REG_OWN_ADDR:   cfg_r.own_address   <= cfg_pwdata[7:0];
        mrv_pkg::REG_READ_CODE:  cfg_r.read_code     <= cfg_pwdata[6:0];
        mrv_pkg::REG_WRITE_CODE: cfg_r.write_code    <= cfg_pwdata[6:0];
        mrv_pkg::REG_MIN_LEN:    cfg_r.min_frame_len <= cfg_pwdata[3:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      mrv_pkg::REG_OWN_ADDR:   cfg_prdata = {24'd0, cfg_r.own_address};
      mrv_pkg::REG_READ_CODE:  cfg_prdata = {25'd0, cfg_r.read_code};
      mrv_pkg::REG_WRITE_CODE: cfg_prdata = {25'd0, cfg_r.write_code};
      mrv_pkg::REG_MIN_LEN:    cfg_prdata = {28'd0, cfg_r.min_frame_len};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  mrv_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cfg        (cfg_r),
    .frame_done (frame_done),
    .mem_wr     (mem_wr),
    .push       (push),
    .push_desc  (push_desc)
  );

  mrv_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  mrv_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .mem_wr     (mem_wr),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (pop),
    .frame_done (frame_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[tb/sv/mrv_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response validator testbench package
// Result beat layout as the checker sees it and the CRC-16 byte update that
// both the frame builder and the checker use.
// ----------------------------------------------------------------------------
package mrv_tb_pkg;

  import mrv_pkg::*;

  // One output beat, unpacked from tdata, tlast and tuser.
  typedef struct packed {
    logic [15:0] reg_word;
    logic        last;
    logic        frame_valid;
    logic        has_exception;
    logic [7:0]  exception_code;
  } result_beat_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[tb/sv/mrv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response validator checker
// Watches the byte, result and register ports, predicts the word and status
// beats of every closed frame and compares them in order, field by field.
// ----------------------------------------------------------------------------
module mrv_checker
  import mrv_pkg::*;
  import mrv_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic        out_tlast,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic [31:0] cfg_prdata,
  input  logic        cfg_pready,
  output int          fail_count,
  output int          pending,
  output int          frames_accepted,
  output int          words_checked
);

  // Shadow registers and the frame state of the predictor.
  cfg_regs_t    regs;
  logic [15:0]  run_crc;
  logic [7:0]   pos_cnt;
  logic [7:0]   addr_b;
  logic [7:0]   func_b;
  logic [7:0]   count_b;
  logic [7:0]   hi_byte;
  logic [15:0]  tail_pair;
  logic [15:0]  word_mem [MAX_WORDS];
  result_beat_t expected_q [$];

  // Print one line per mismatch; after the first 30 only the count grows.
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (fail_count < 30) begin
      $display("ERROR at %0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
    fail_count++;
  endtask

  task automatic clear_frame();
    run_crc   = CRC_INIT;
    pos_cnt   = '0;
    addr_b    = '0;
    func_b    = '0;
    count_b   = '0;
    hi_byte   = '0;
    tail_pair = '0;
  endtask

  // Register write or read-back check on the access cycle.
  task automatic cfg_access();
    logic [31:0] cur;
    case (reg_idx_t'(cfg_paddr[3:2]))
      REG_OWN_ADDR:   cur = {24'h0, regs.own_address};
      REG_READ_CODE:  cur = {25'h0, regs.read_code};
      REG_WRITE_CODE: cur = {25'h0, regs.write_code};
      default:        cur = {28'h0, regs.min_frame_len};
    endcase
    if (!cfg_pwrite) begin
      if (cfg_prdata !== cur) note_mismatch("register read-back", cfg_prdata, cur);
    end else begin
      case (reg_idx_t'(cfg_paddr[3:2]))
        REG_OWN_ADDR:   regs.own_address   = cfg_pwdata[7:0];
        REG_READ_CODE:  regs.read_code     = cfg_pwdata[6:0];
        REG_WRITE_CODE: regs.write_code    = cfg_pwdata[6:0];
        default:        regs.min_frame_len = cfg_pwdata[3:0];
      endcase
    end
  endtask

  // Advance the frame state by one byte; at frame end queue the word beats
  // of an accepted normal response and then the status beat.
  task automatic take_byte(input logic [7:0] b, input logic eof);
    int unsigned  off;
    int unsigned  idx;
    int unsigned  len;
    int unsigned  minlen;
    int unsigned  nw;
    logic         ok;
    logic         exc;
    result_beat_t r;
    // The CRC runs two bytes behind, so the last two stay out of it.
    if (pos_cnt >= 8'd2) run_crc = crc16_feed(run_crc, tail_pair[15:8]);
    tail_pair = {tail_pair[7:0], b};
    case (pos_cnt)
      8'(POS_ADDR):  addr_b  = b;
      8'(POS_FUNC):  func_b  = b;
      8'(POS_COUNT): count_b = b;
      default: begin
        off = pos_cnt - POS_DATA;
        if (!off[0]) begin
          hi_byte = b;
        end else begin
          idx = off / 2;
          if (idx < MAX_WORDS) word_mem[idx] = {hi_byte, b};
        end
      end
    endcase
    if (pos_cnt != POS_MAX) pos_cnt++;

    if (eof) begin
      len    = pos_cnt;
      minlen = (regs.min_frame_len < MIN_LEN_FLOOR) ? MIN_LEN_FLOOR : regs.min_frame_len;
      exc    = func_b[7];
      ok = (len >= minlen) && (len <= MAX_FRAME_LEN) &&
           (run_crc == {tail_pair[7:0], tail_pair[15:8]}) &&
           (func_b[6:0] == regs.read_code || func_b[6:0] == regs.write_code) &&
           (regs.own_address == ANY_ADDR || regs.own_address == addr_b) &&
           (exc || (count_b + LEN_OVERHEAD == len));

      if (ok && !exc) begin
        nw = (count_b + 1) / 2;
        if (nw > MAX_WORDS) nw = MAX_WORDS;
        for (int k = 0; k < nw; k++) begin
          r = '0;
          r.reg_word = word_mem[k];
          expected_q.push_back(r);
        end
      end
      r = '0;
      r.last           = 1'b1;
      r.frame_valid    = ok;
      r.has_exception  = ok && exc;
      r.exception_code = (ok && exc) ? count_b : 8'h00;
      expected_q.push_back(r);
      if (ok) frames_accepted++;
      clear_frame();
    end
  endtask

  // Compare one result beat with the oldest expectation.
  task automatic check_beat();
    result_beat_t want;
    if (expected_q.size() == 0) begin
      note_mismatch("result beat with nothing expected", out_tdata, 32'h0);
    end else begin
      want = expected_q.pop_front();
      if (out_tdata[15:0] !== want.reg_word)
        note_mismatch("reg_word", out_tdata[15:0], want.reg_word);
      if (out_tlast !== want.last)
        note_mismatch("last", out_tlast, want.last);
      if (out_tuser[0] !== want.frame_valid)
        note_mismatch("frame_valid", out_tuser[0], want.frame_valid);
      if (out_tuser[1] !== want.has_exception)
        note_mismatch("has_exception", out_tuser[1], want.has_exception);
      if (out_tdata[23:16] !== want.exception_code)
        note_mismatch("exception_code", out_tdata[23:16], want.exception_code);
      if (!want.last) words_checked++;
    end
  endtask

  // All three ports are sampled at the rising edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      regs.own_address   = 8'd255;
      regs.read_code     = 7'd3;
      regs.write_code    = 7'd16;
      regs.min_frame_len = 4'd5;
      clear_frame();
      expected_q.delete();
      fail_count      = 0;
      frames_accepted = 0;
      words_checked   = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) cfg_access();
      if (out_tvalid && out_tready) check_beat();
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
    end
    pending = expected_q.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response validator testbench
// Sends directed and random response frames (good, exception, corrupted,
// misaddressed, noise and oversized) under several register settings, with
// random gaps on both streams; the checker predicts and compares the beats.
// ----------------------------------------------------------------------------
module tb_top;

  import mrv_pkg::*;
  import mrv_tb_pkg::*;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata    = 8'h00;
  logic        in_tlast    = 1'b0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;
  logic [1:0]  out_tuser;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = 4'h0;
  logic [31:0] cfg_pwdata  = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int fail_count;
  int pending;
  int frames_accepted;
  int words_checked;

  // Stimulus side copy of the registers, used to shape well-formed frames.
  logic [7:0] cur_own = 8'd255;
  logic [6:0] cur_rd  = 7'd3;
  logic [6:0] cur_wr  = 7'd16;
  logic       gaps_on = 1'b1;
  logic [7:0] frame_q [$];
  int         bytes_sent  = 0;
  int         frames_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  modbus_rtu_response_validator i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),     // [7:0] data_byte
    .in_tlast    (in_tlast),     // frame_end
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),    // [15:0] reg_word, [23:16] exception_code
    .out_tlast   (out_tlast),    // last
    .out_tuser   (out_tuser),    // [0] frame_valid, [1] has_exception
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  mrv_checker i_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tlast        (in_tlast),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tlast       (out_tlast),
    .out_tuser       (out_tuser),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .fail_count      (fail_count),
    .pending         (pending),
    .frames_accepted (frames_accepted),
    .words_checked   (words_checked)
  );

  // The result side stalls at random about a fifth of the time while gaps are on.
  always @(negedge clk) begin
    out_tready <= !gaps_on || ($urandom_range(99) >= 20);
  end

  // Offer one byte, with random idle cycles first, and hold it until taken.
  task automatic send_beat(input logic [7:0] b, input logic eof);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_beat(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  // Stop sending until every expected beat is out, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // One register access: setup phase, then access phase until pready.
  task automatic cfg_access(input logic wr, input reg_idx_t idx, input logic [31:0] v);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= v;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write all four registers while the block is idle and read them back.
  task automatic set_regs(input logic [7:0] own, input logic [6:0] rd,
                          input logic [6:0] wr, input logic [3:0] minl);
    wait_drained();
    cfg_access(1'b1, REG_OWN_ADDR,   {24'h0, own});
    cfg_access(1'b1, REG_READ_CODE,  {25'h0, rd});
    cfg_access(1'b1, REG_WRITE_CODE, {25'h0, wr});
    cfg_access(1'b1, REG_MIN_LEN,    {28'h0, minl});
    cfg_access(1'b0, REG_OWN_ADDR,   32'h0);
    cfg_access(1'b0, REG_READ_CODE,  32'h0);
    cfg_access(1'b0, REG_WRITE_CODE, 32'h0);
    cfg_access(1'b0, REG_MIN_LEN,    32'h0);
    cur_own = own;
    cur_rd  = rd;
    cur_wr  = wr;
  endtask

  // Append the CRC of the bytes so far, low byte first.
  task automatic seal_crc();
    logic [15:0] crc;
    crc = CRC_INIT;
    foreach (frame_q[i]) crc = crc16_feed(crc, frame_q[i]);
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
  endtask

  task automatic build_normal(input logic [7:0] a, input logic [7:0] f,
                              input logic [7:0] cnt, input int unsigned ndata);
    frame_q = {};
    frame_q.push_back(a);
    frame_q.push_back(f);
    frame_q.push_back(cnt);
    repeat (ndata) frame_q.push_back(8'($urandom));
    seal_crc();
  endtask

  // Mostly well-formed responses with random content; the rest exceptions,
  // bit errors, wrong header fields with a good CRC, and raw noise.
  task automatic send_random_frame();
    int unsigned kind;
    int unsigned cnt;
    int unsigned k;
    logic [7:0]  a;
    logic [7:0]  f;
    kind = $urandom_range(99);
    a    = (cur_own == ANY_ADDR) ? 8'($urandom) : cur_own;
    f    = {1'b0, ($urandom_range(1) == 1) ? cur_rd : cur_wr};
    cnt  = ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(12);
    if (kind < 12) begin
      // Exception reply; now and then without its code byte.
      frame_q = {};
      frame_q.push_back(a);
      frame_q.push_back(f | 8'h80);
      if ($urandom_range(3) != 0) frame_q.push_back(8'($urandom));
      seal_crc();
    end else if (kind < 72) begin
      build_normal(a, f, 8'(cnt), cnt);
    end else if (kind < 82) begin
      build_normal(a, f, 8'(cnt), cnt);
      k = $urandom_range(frame_q.size() - 1);
      frame_q[k] = frame_q[k] ^ (8'h01 << $urandom_range(7));
    end else if (kind < 92) begin
      case ($urandom_range(2))
        0:       build_normal(a ^ 8'($urandom_range(1, 255)), f, 8'(cnt), cnt);
        1:       build_normal(a, 8'($urandom), 8'(cnt), cnt);
        default: build_normal(a, f, 8'(cnt + 1), cnt);
      endcase
    end else begin
      frame_q = {};
      repeat ($urandom_range(1, 10)) frame_q.push_back(8'($urandom));
    end
    if ($urandom_range(39) == 0) wait_drained();
    send_frame();
  endtask

  task automatic run_random(input int nbytes);
    int stop_at;
    stop_at = bytes_sent + nbytes;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed frames under the reset settings: read reply with extreme
    // data bytes, write reply with an odd byte count, an exception, a
    // one-byte and a three-byte frame, and an empty read reply.
    frame_q = {8'h00, 8'h03, 8'h02, 8'hFF, 8'h00};
    seal_crc();
    send_frame();
    frame_q = {8'hFF, 8'h10, 8'h01, 8'h80};
    seal_crc();
    send_frame();
    frame_q = {8'h11, 8'h83, 8'h02};
    seal_crc();
    send_frame();
    frame_q = {8'hFF};
    send_frame();
    frame_q = {8'h01, 8'h03, 8'h00};
    send_frame();
    frame_q = {8'h7E, 8'h03, 8'h00};
    seal_crc();
    send_frame();

    run_random(18);
    set_regs(8'h00, 7'h00, 7'h7F, 4'd4);
    run_random(18);
    set_regs(ANY_ADDR, 7'h7F, 7'h00, 4'd8);
    run_random(18);
    // A minimum below four acts as four; short exception replies pass here.
    set_regs(8'($urandom_range(254)), 7'($urandom), 7'($urandom), 4'd2);
    run_random(18);
    set_regs(8'($urandom_range(254)), 7'($urandom), 7'($urandom), 4'd15);
    run_random(18);

    // A long stretch without any idling on either side.
    set_regs(ANY_ADDR, 7'd3, 7'd16, 4'd6);
    gaps_on = 1'b0;
    run_random(40);
    gaps_on = 1'b1;

    set_regs(8'($urandom_range(254)), 7'd3, 7'd16, 4'($urandom_range(4, 8)));
    run_random(10);

    // More words than the buffer holds; the frame must be rejected.
    build_normal(cur_own, {1'b0, cur_rd}, 8'd70, 70);
    send_frame();
    run_random(5);

    wait_drained();
    repeat (100) @(negedge clk);
    $display("Sent %0d frames (%0d bytes) over seven register settings, incl. oversized,",
             frames_sent, bytes_sent);
    $display("corrupted and noise frames: %0d accepted, %0d register words compared.",
             frames_accepted, words_checked);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #400000;
    $display("Timeout with %0d result beats still expected.", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule

[modbus_rtu_response_validator.f]
hw/rtl/mrv_pkg.sv
hw/rtl/mrv_front.sv
hw/rtl/mrv_queue.sv
hw/rtl/mrv_back.sv
hw/rtl/modbus_rtu_response_validator.sv
tb/sv/mrv_tb_pkg.sv
tb/sv/mrv_checker.sv
tb/sv/tb_top.sv
